@@ src/htn_pkg.sv @@
// Shared types and constants for the height-map to normal-map block.
// No dependencies; every other file imports this package.
package htn_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = HEIGHT_REG_W;

  // 255^2: scale of the z term and of the right-hand side of the compare
  localparam int ENC_SCALE    = 65025;

  // one setup stage plus two stages per code bit
  localparam int LANE_STAGES  = 17;
  // front, difference, square, sum, then the encoder lanes
  localparam int PIPE_STAGES  = 4 + LANE_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] in_alpha;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } in_pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       run_last;
    logic       frame_end;
  } out_pix_t;

  // per-item side information that travels along the pipeline
  typedef struct packed {
    logic [31:0] pix;
    logic [31:0] above;
    logic        has_a;
    logic        has_b;
    logic        last_col;
    logic        last_row;
  } info_t;

  // what the result serializer receives at the end of the pipeline
  typedef struct packed {
    info_t      info;
    logic [7:0] nx;
    logic [7:0] ny;
    logic [7:0] nz;
  } out_item_t;

endpackage

@@ src/height_to_normal_map.sv @@
// Top level of the height-map to normal-map converter.
// Depends on htn_pkg, htn_front, htn_enc_lane and htn_out.

// Pixels enter in raster order and leave one row later. Every pixel that is
// not in the last row or last column becomes an encoded normal (x, y, z from
// the red-channel differences to the right and lower neighbor, alpha 255);
// last-column pixels leave unchanged, and each last-row pixel is also passed
// straight on as a second result of its own transfer. One pixel is taken per
// clock unless the output stalls: the pipeline is 21 stages deep (line store
// read, differences, squares, sum, then three parallel encoder lanes that
// settle one code bit every two stages with a 16x18 multiply each) plus the
// output register. In the last row each pixel gives two results on the single
// output port, which holds the input back. The line store is one memory of
// MAX_WIDTH pixels with one write and one read per transfer; no clearing pass
// is needed. Image size is written through the config port (index 0: width,
// index 1: height), by the user only while idle; the block does not enforce it.
module height_to_normal_map
  import htn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_pix_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_pix_t              out_data_o
);

  localparam int LAST = PIPE_STAGES - 1;

  logic [PIPE_STAGES-1:0] v_q;
  logic [PIPE_STAGES-1:0] en;
  logic                   accept;
  logic                   take;

  info_t      s0_info;
  logic [7:0] right_red;
  info_t      info_q [PIPE_STAGES-1];

  // stage 1: differences
  logic signed [8:0] dd_q, db_q;
  // stage 2: squares
  logic [15:0] sqd2_q, sqb2_q;
  logic        ndd2_q, ndb2_q;
  logic signed [17:0] pdd, pdb;
  // stage 3: sum of squares plus ENC_SCALE
  logic [17:0] s3_q;
  logic [15:0] sqd3_q, sqb3_q;
  logic        ndd3_q, ndb3_q;

  logic [7:0] nx, ny, nz;
  out_item_t  item;

  assign cfg_ready_o = 1'b1;

  // ready ripples back from the output; a bubble lets the stages above move
  always_comb begin
    en[LAST] = !v_q[LAST] || take;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];
  assign accept     = in_valid_i && en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  htn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pix_i       (in_data_i),
    .info_o      (s0_info),
    .right_red_o (right_red)
  );

  // side info delay line, element i holds stage i+1
  always_ff @(posedge clk_i) begin
    if (en[1]) info_q[0] <= s0_info;
    for (int i = 2; i < PIPE_STAGES; i++) begin
      if (en[i]) info_q[i-1] <= info_q[i-2];
    end
  end

  assign pdd = dd_q * dd_q;
  assign pdb = db_q * db_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      dd_q <= $signed({1'b0, right_red}) - $signed({1'b0, s0_info.above[7:0]});
      db_q <= $signed({1'b0, s0_info.pix[7:0]}) - $signed({1'b0, s0_info.above[7:0]});
    end
    if (en[2]) begin
      sqd2_q <= pdd[15:0];
      sqb2_q <= pdb[15:0];
      ndd2_q <= dd_q[8];
      ndb2_q <= db_q[8];
    end
    if (en[3]) begin
      s3_q   <= 18'(sqd2_q) + 18'(sqb2_q) + 18'(ENC_SCALE);
      sqd3_q <= sqd2_q;
      sqb3_q <= sqb2_q;
      ndd3_q <= ndd2_q;
      ndb3_q <= ndb2_q;
    end
  end

  htn_enc_lane u_lane_x (
    .clk_i  (clk_i),
    .en_i   (en[PIPE_STAGES-1 -: LANE_STAGES]),
    .neg_i  (ndd3_q),
    .dsq_i  (sqd3_q),
    .s_i    (s3_q),
    .code_o (nx)
  );

  htn_enc_lane u_lane_y (
    .clk_i  (clk_i),
    .en_i   (en[PIPE_STAGES-1 -: LANE_STAGES]),
    .neg_i  (ndb3_q),
    .dsq_i  (sqb3_q),
    .s_i    (s3_q),
    .code_o (ny)
  );

  // z uses d = 255
  htn_enc_lane u_lane_z (
    .clk_i  (clk_i),
    .en_i   (en[PIPE_STAGES-1 -: LANE_STAGES]),
    .neg_i  (1'b0),
    .dsq_i  (16'(ENC_SCALE)),
    .s_i    (s3_q),
    .code_o (nz)
  );

  always_comb begin
    item.info = info_q[LAST-1];
    item.nx   = nx;
    item.ny   = ny;
    item.nz   = nz;
  end

  htn_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (v_q[LAST]),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  // the frame end marker only sits on the last result of a transfer
  a_fe_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.run_last)
    else $error("frame_end without run_last");

  // a first result of two is always followed by the second
  a_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.run_last |=> out_valid_o)
    else $error("second result missing");

  // input is held off only when the front stage is occupied
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v_q[0])
    else $error("input stalled with empty front stage");
`endif

endmodule

@@ src/htn_front.sv @@
// Input side: size registers, raster counters and the line store.
// Depends on htn_pkg.
module htn_front
  import htn_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic [31:0]           pix_i,
  output info_t                 info_o,
  output logic [7:0]            right_red_o
);

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [COL_W-1:0]        col_q;
  logic [ROW_W-1:0]        row_q;
  logic                    last_col;
  logic                    last_row;
  logic [COL_W-1:0]        raddr;

  logic [31:0] mem [MAX_WIDTH];
  logic [31:0] rdata_q;
  logic        byp_q;
  logic [31:0] byp_pix_q;
  info_t       info_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_REG_W'(MAX_WIDTH);
      height_q <= HEIGHT_REG_W'(2048);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    if (width_q == '0) w_eff = WIDTH_REG_W'(1);
    else if (width_q > WIDTH_REG_W'(MAX_WIDTH)) w_eff = WIDTH_REG_W'(MAX_WIDTH);
    else w_eff = width_q;
    if (height_q == '0) h_eff = HEIGHT_REG_W'(1);
    else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    else h_eff = height_q;
  end

  assign last_col = WIDTH_REG_W'(col_q) >= (w_eff - WIDTH_REG_W'(1));
  assign last_row = HEIGHT_REG_W'(row_q) >= (h_eff - HEIGHT_REG_W'(1));
  // prefetch the pixel above the next column
  assign raddr    = last_col ? '0 : col_q + COL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      byp_q <= 1'b0;
    end else if (accept_i) begin
      // single-column frame: the prefetch hits the entry written right now
      byp_q <= last_col && (col_q == '0);
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      mem[col_q] <= pix_i;
      rdata_q    <= mem[raddr];
      byp_pix_q  <= pix_i;
      info_q.pix      <= pix_i;
      info_q.above    <= byp_q ? byp_pix_q : rdata_q;
      info_q.has_a    <= row_q != '0;
      info_q.has_b    <= last_row;
      info_q.last_col <= last_col;
      info_q.last_row <= last_row;
    end
  end

  assign info_o      = info_q;
  assign right_red_o = rdata_q[7:0];

endmodule

@@ src/htn_enc_lane.sv @@
// One channel encoder: bit-by-bit search of floor(127.5*(1 + d/sqrt(s))).
// Depends on htn_pkg.
module htn_enc_lane
  import htn_pkg::*;
(
  input  logic                   clk_i,
  input  logic [LANE_STAGES-1:0] en_i,
  input  logic                   neg_i,
  input  logic [15:0]            dsq_i,
  input  logic [17:0]            s_i,
  output logic [7:0]             code_o
);

  logic [7:0]  k_q    [LANE_STAGES];
  logic        neg_q  [LANE_STAGES];
  logic [17:0] s_q    [LANE_STAGES];
  logic [31:0] ksq_q  [LANE_STAGES];
  logic [15:0] tsq_q  [LANE_STAGES];
  logic        tpos_q [LANE_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      k_q[0]    <= '0;
      neg_q[0]  <= neg_i;
      s_q[0]    <= s_i;
      ksq_q[0]  <= 32'(ENC_SCALE) * 32'(dsq_i);
      tsq_q[0]  <= '0;
      tpos_q[0] <= 1'b0;
    end
  end

  for (genvar j = 1; j < LANE_STAGES; j++) begin : g_step
    localparam int B = 7 - (j - 1) / 2;
    logic [7:0]  cand;
    logic [8:0]  t2;
    logic [7:0]  tabs;
    logic [33:0] lhs;
    logic        fit;

    always_comb begin
      cand = k_q[j-1] | (8'd1 << B);
      t2   = {cand, 1'b0};
      tabs = cand[7] ? 8'(t2 - 9'd255) : 8'(9'd255 - t2);
      lhs  = 34'(tsq_q[j-1]) * 34'(s_q[j-1]);
      // t = 2*cand - 255; test t*sqrt(s) <= 255*d
      if (!tpos_q[j-1] && !neg_q[j-1]) fit = 1'b1;
      else if (tpos_q[j-1] && neg_q[j-1]) fit = 1'b0;
      else if (tpos_q[j-1]) fit = lhs <= 34'(ksq_q[j-1]);
      else fit = lhs >= 34'(ksq_q[j-1]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        neg_q[j] <= neg_q[j-1];
        s_q[j]   <= s_q[j-1];
        ksq_q[j] <= ksq_q[j-1];
        if ((j % 2) == 1) begin
          // square |t| for this candidate
          k_q[j]    <= k_q[j-1];
          tsq_q[j]  <= 16'(tabs) * 16'(tabs);
          tpos_q[j] <= cand[7];
        end else begin
          // multiply by s, compare, keep the bit
          k_q[j]    <= fit ? cand : k_q[j-1];
          tsq_q[j]  <= tsq_q[j-1];
          tpos_q[j] <= tpos_q[j-1];
        end
      end
    end
  end

  assign code_o = k_q[LANE_STAGES-1];

endmodule

@@ src/htn_out.sv @@
// Result serializer: zero, one or two results per item, registered output.
// Depends on htn_pkg.
module htn_out
  import htn_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  out_item_t item_i,
  output logic      take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_pix_t  out_data_o
);

  out_item_t item_q;
  logic      busy_q;
  logic      phase_q;
  logic      final_res;
  logic      xfer;
  logic      fe;
  logic [31:0] val;

  assign final_res = phase_q || !item_q.info.has_b;
  assign xfer      = busy_q && out_ready_i;
  assign take_o    = !busy_q || (xfer && final_res);
  assign fe        = item_q.info.last_col && item_q.info.last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (take_o) begin
      busy_q  <= item_valid_i && (item_i.info.has_a || item_i.info.has_b);
      phase_q <= !item_i.info.has_a;
    end else if (xfer) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) item_q <= item_i;
  end

  always_comb begin
    if (phase_q) val = item_q.info.pix;
    else if (item_q.info.last_col) val = item_q.info.above;
    else val = {8'hFF, item_q.nz, item_q.ny, item_q.nx};
    out_data_o.out_red   = val[7:0];
    out_data_o.out_green = val[15:8];
    out_data_o.out_blue  = val[23:16];
    out_data_o.out_alpha = val[31:24];
    out_data_o.run_last  = final_res;
    out_data_o.frame_end = final_res && fe;
  end

  assign out_valid_o = busy_q;

endmodule
